@@ design/mpt_pkg.sv @@
// Package for the mouse pointer tracker: event and function codes, register
// indexes and the structs passed between the top level and the update logic.
// Depends on nothing.
package mpt_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned PRESS_BIT  = 7;

   typedef enum logic [2:0] {
      FUNC_MOVE_X  = 3'd0,
      FUNC_MOVE_Y  = 3'd1,
      FUNC_WHEEL   = 3'd2,
      FUNC_BUTTON0 = 3'd3,
      FUNC_BUTTON1 = 3'd4,
      FUNC_BUTTON2 = 3'd5,
      FUNC_SET_POS = 3'd6
   } func_type;

   typedef enum logic [3:0] {
      EV_MOVE        = 4'd0,
      EV_WHEEL_DOWN  = 4'd1,
      EV_WHEEL_UP    = 4'd2,
      EV_LEFT_DOWN   = 4'd3,
      EV_LEFT_UP     = 4'd4,
      EV_RIGHT_DOWN  = 4'd5,
      EV_RIGHT_UP    = 4'd6,
      EV_CENTER_DOWN = 4'd7,
      EV_CENTER_UP   = 4'd8
   } event_type;

   typedef enum logic [2:0] {
      REG_BASE_THRESH  = 3'd0,
      REG_BOOST_THRESH = 3'd1,
      REG_ACCEL_STEPS  = 3'd2,
      REG_LIMIT_X      = 3'd3,
      REG_LIMIT_Y      = 3'd4,
      REG_SWAP_BUTTONS = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [15:0] base_thresh;
      logic [15:0] boost_thresh;
      logic [1:0]  accel_steps;
      logic [15:0] limit_x;
      logic [15:0] limit_y;
      logic        swap_buttons;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [15:0] value;
      logic [15:0]        new_x;
      logic [15:0]        new_y;
   } item_type;

   typedef struct packed {
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic signed [31:0] wheel_total;
   } state_type;

   typedef struct packed {
      logic [3:0]         event_res;
      logic [15:0]        pos_x_out;
      logic [15:0]        pos_y_out;
      logic signed [31:0] wheel_out;
   } result_type;

endpackage

@@ design/mpt_if.sv @@
// Valid/ready channel interfaces for the request and response sides of the
// mouse pointer tracker. Depends on nothing but plain logic types.
interface mpt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic signed [15:0] value;
   logic [15:0]        new_x;
   logic [15:0]        new_y;

   modport source (output valid, func, value, new_x, new_y, input ready);
   modport sink   (input valid, func, value, new_x, new_y, output ready);
endinterface

interface mpt_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         event_res;
   logic [15:0]        pos_x_out;
   logic [15:0]        pos_y_out;
   logic signed [31:0] wheel_out;

   modport source (output valid, event_res, pos_x_out, pos_y_out, wheel_out, input ready);
   modport sink   (input valid, event_res, pos_x_out, pos_y_out, wheel_out, output ready);
endinterface

@@ design/mpt_core.sv @@
// Combinational update for one mouse event: acceleration, clamping, wheel
// accumulation and button mapping. Depends on mpt_pkg.
module mpt_core (
   input  mpt_pkg::item_type   item,
   input  mpt_pkg::cfg_type    cfg,
   input  mpt_pkg::state_type  state,
   output mpt_pkg::state_type  state_next,
   output mpt_pkg::result_type result,
   output logic                has_result
);
   import mpt_pkg::*;

   // Accelerate the delta and add it to the position, clamping to 0..lim.
   function automatic logic [15:0] move_clamp(
      input logic [15:0]        pos,
      input logic signed [15:0] d,
      input logic [15:0]        lim,
      input cfg_type            c
   );
      logic [16:0]        mag;
      logic [1:0]         shift;
      logic signed [18:0] delta;
      logic signed [19:0] sum;
      logic [15:0]        res;
      // The magnitude of the most negative delta does not fit the signed sixteen-bit delta.
      mag   = d[15] ? (17'd0 - {1'b1, d}) : {1'b0, d};
      shift = 2'd0;
      if (c.accel_steps != 2'd0 && {1'b0, c.base_thresh} < mag) begin
         shift = shift + 2'd1;
      end
      if (c.accel_steps[1] && {1'b0, c.boost_thresh} < mag) begin
         shift = shift + 2'd1;
      end
      delta = $signed(19'(d)) <<< shift;
      sum   = $signed({4'b0000, pos}) + $signed(20'(delta));
      if (sum[19]) begin
         res = 16'd0;
      end else if (sum[18:0] > {3'b000, lim}) begin
         res = lim;
      end else begin
         res = sum[15:0];
      end
      return res;
   endfunction

   logic pressed;
   logic is_left;
   logic [3:0] ev;

   assign pressed = item.value[PRESS_BIT];
   assign is_left = (item.func == FUNC_BUTTON0) ^ cfg.swap_buttons;

   always_comb begin
      state_next = state;
      ev         = EV_MOVE;
      has_result = 1'b1;
      case (item.func)
         FUNC_MOVE_X: begin
            state_next.pos_x = move_clamp(state.pos_x, item.value, cfg.limit_x, cfg);
         end
         FUNC_MOVE_Y: begin
            state_next.pos_y = move_clamp(state.pos_y, item.value, cfg.limit_y, cfg);
         end
         FUNC_WHEEL: begin
            state_next.wheel_total = state.wheel_total + 32'(item.value);
            ev = item.value[15] ? EV_WHEEL_DOWN : EV_WHEEL_UP;
         end
         FUNC_BUTTON0, FUNC_BUTTON1: begin
            if (is_left) begin
               ev = pressed ? EV_LEFT_DOWN : EV_LEFT_UP;
            end else begin
               ev = pressed ? EV_RIGHT_DOWN : EV_RIGHT_UP;
            end
         end
         FUNC_BUTTON2: begin
            ev = pressed ? EV_CENTER_DOWN : EV_CENTER_UP;
         end
         FUNC_SET_POS: begin
            state_next.pos_x = item.new_x;
            state_next.pos_y = item.new_y;
            has_result       = 1'b0;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   assign result.event_res = ev;
   assign result.pos_x_out = state_next.pos_x;
   assign result.pos_y_out = state_next.pos_y;
   assign result.wheel_out = state_next.wheel_total;

endmodule

@@ design/mouse_pointer_tracker.sv @@
// Mouse pointer tracker: a request transfer loads the input register, the item's
// result is then loaded into the result register, and the response is offered
// from there.
// Throughput is one event per cycle; a response held by the receiver stalls
// the request side. Set-position and unused codes give no response.
// Synchronous reset clears position, wheel total, registers and both stages.
module mouse_pointer_tracker (
   input  logic                             clock,
   input  logic                             reset,
   mpt_req_if.sink                          req_ch,
   mpt_rsp_if.source                        rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mpt_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mpt_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mpt_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import mpt_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   state_type  state_ff;
   state_type  state_calc;
   item_type   s1_item_ff;
   logic       s1_valid_ff;
   result_type rsp_data_ff;
   result_type result_calc;
   logic       rsp_valid_ff;
   logic       has_result;
   logic       out_free;
   logic       s1_adv;
   logic       req_take;
   logic       csr_write;
   logic [2:0] csr_index;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_BASE_THRESH:  cfg_in.base_thresh  = csr_pwdata[15:0];
            REG_BOOST_THRESH: cfg_in.boost_thresh = csr_pwdata[15:0];
            REG_ACCEL_STEPS:  cfg_in.accel_steps  = csr_pwdata[1:0];
            REG_LIMIT_X:      cfg_in.limit_x      = csr_pwdata[15:0];
            REG_LIMIT_Y:      cfg_in.limit_y      = csr_pwdata[15:0];
            REG_SWAP_BUTTONS: cfg_in.swap_buttons = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_BASE_THRESH:  csr_prdata = {16'd0, cfg_ff.base_thresh};
         REG_BOOST_THRESH: csr_prdata = {16'd0, cfg_ff.boost_thresh};
         REG_ACCEL_STEPS:  csr_prdata = {30'd0, cfg_ff.accel_steps};
         REG_LIMIT_X:      csr_prdata = {16'd0, cfg_ff.limit_x};
         REG_LIMIT_Y:      csr_prdata = {16'd0, cfg_ff.limit_y};
         REG_SWAP_BUTTONS: csr_prdata = {31'd0, cfg_ff.swap_buttons};
         default:          csr_prdata = '0;
      endcase
   end

   mpt_core u_core (
      .item       (s1_item_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_calc),
      .result     (result_calc),
      .has_result (has_result)
   );

   // The held item moves on when its result has room, or when it has none.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && (!has_result || out_free);
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         state_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (s1_adv) begin
            state_ff <= state_calc;
         end
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (s1_adv && has_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.func  <= req_ch.func;
         s1_item_ff.value <= req_ch.value;
         s1_item_ff.new_x <= req_ch.new_x;
         s1_item_ff.new_y <= req_ch.new_y;
      end
      if (s1_adv && has_result) begin
         rsp_data_ff <= result_calc;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.event_res = rsp_data_ff.event_res;
   assign rsp_ch.pos_x_out = rsp_data_ff.pos_x_out;
   assign rsp_ch.pos_y_out = rsp_data_ff.pos_y_out;
   assign rsp_ch.wheel_out = rsp_data_ff.wheel_out;

`ifndef SYNTHESIS
   a_setpos_loads: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_item_ff.func == FUNC_SET_POS) |=>
         (state_ff.pos_x == $past(s1_item_ff.new_x) &&
          state_ff.pos_y == $past(s1_item_ff.new_y)))
      else $error("set position did not load the position");

   a_move_x_clamped: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_item_ff.func == FUNC_MOVE_X) |=> (state_ff.pos_x <= cfg_ff.limit_x))
      else $error("horizontal position beyond its limit after a move");

   a_move_y_clamped: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_item_ff.func == FUNC_MOVE_Y) |=> (state_ff.pos_y <= cfg_ff.limit_y))
      else $error("vertical position beyond its limit after a move");

   a_wheel_only_on_wheel: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_item_ff.func != FUNC_WHEEL) |=> $stable(state_ff.wheel_total))
      else $error("wheel total changed by a non-wheel event");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request side stalled with nothing held");
`endif

endmodule

@@ tb/mouse_pointer_tracker_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for mouse_pointer_tracker: directed and random mouse events,
// checked against a local pointer model with register writes over the APB-style port.
// Depends on mpt_pkg, the mpt_req_if/mpt_rsp_if interfaces and the tracker RTL.
module mouse_pointer_tracker_tb;
   import mpt_pkg::*;

   localparam logic [2:0] FUNC_UNUSED     = 3'd7;
   localparam int         QUIET_LIMIT     = 2000;
   localparam int         HOLD_OFF_CYCLES = 120;
   localparam int         PHASE_EVENTS    = 130;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   mpt_req_if req_ch ();
   mpt_rsp_if rsp_ch ();

   mouse_pointer_tracker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Local copy of the pointer state and of the register settings.
   cfg_type            pointer_cfg;
   logic [15:0]        track_x;
   logic [15:0]        track_y;
   logic signed [31:0] wheel_sum;
   result_type         reports_due[$];

   int mismatch_count = 0;
   int tx_gap_pct     = 0;
   int rx_stall_pct   = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [15:0] moved_position(input logic [15:0]        pos,
                                                  input logic signed [15:0] delta,
                                                  input logic [15:0]        lim);
      int step;
      int mag;
      int sum;
      step = delta;
      mag  = (step < 0) ? -step : step;
      // Both threshold tests are strict; level 3 doubles twice as level 2 does.
      if (pointer_cfg.accel_steps >= 2'd1 && int'(pointer_cfg.base_thresh) < mag) begin
         step = step * 2;
      end
      if (pointer_cfg.accel_steps >= 2'd2 && int'(pointer_cfg.boost_thresh) < mag) begin
         step = step * 2;
      end
      sum = int'(pos) + step;
      if (sum < 0) begin
         sum = 0;
      end else if (sum > int'(lim)) begin
         sum = int'(lim);
      end
      return sum[15:0];
   endfunction

   task automatic track_pointer_event(input item_type it);
      result_type due;
      logic       on_left;
      due     = '0;
      on_left = 1'b0;
      case (it.func)
         FUNC_MOVE_X: begin
            track_x       = moved_position(track_x, it.value, pointer_cfg.limit_x);
            due.event_res = EV_MOVE;
         end
         FUNC_MOVE_Y: begin
            track_y       = moved_position(track_y, it.value, pointer_cfg.limit_y);
            due.event_res = EV_MOVE;
         end
         FUNC_WHEEL: begin
            wheel_sum     = wheel_sum + 32'(it.value);
            due.event_res = (it.value < 0) ? EV_WHEEL_DOWN : EV_WHEEL_UP;
         end
         FUNC_BUTTON0, FUNC_BUTTON1: begin
            on_left = (it.func == FUNC_BUTTON0) ^ pointer_cfg.swap_buttons;
            if (on_left) begin
               due.event_res = it.value[PRESS_BIT] ? EV_LEFT_DOWN : EV_LEFT_UP;
            end else begin
               due.event_res = it.value[PRESS_BIT] ? EV_RIGHT_DOWN : EV_RIGHT_UP;
            end
         end
         FUNC_BUTTON2: begin
            due.event_res = it.value[PRESS_BIT] ? EV_CENTER_DOWN : EV_CENTER_UP;
         end
         FUNC_SET_POS: begin
            // Forced positions are taken as they are, even beyond the limits.
            track_x = it.new_x;
            track_y = it.new_y;
            return;
         end
         default: begin
            return;
         end
      endcase
      due.pos_x_out = track_x;
      due.pos_y_out = track_y;
      due.wheel_out = wheel_sum;
      reports_due.push_back(due);
   endtask

   // The request stays offered until the next falling edge, where the next send
   // replaces it or wait_drained withdraws it.
   task automatic send_event(input logic [2:0] func, input logic signed [15:0] value,
                             input logic [15:0] x = 16'd0, input logic [15:0] y = 16'd0);
      item_type it;
      it.func  = func;
      it.value = value;
      it.new_x = x;
      it.new_y = y;
      @(negedge clock);
      while ($urandom_range(99) < tx_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= func;
      req_ch.value <= value;
      req_ch.new_x <= x;
      req_ch.new_y <= y;
      do @(posedge clock); while (!req_ch.ready);
      track_pointer_event(it);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_BASE_THRESH:  pointer_cfg.base_thresh  = data[15:0];
         REG_BOOST_THRESH: pointer_cfg.boost_thresh = data[15:0];
         REG_ACCEL_STEPS:  pointer_cfg.accel_steps  = data[1:0];
         REG_LIMIT_X:      pointer_cfg.limit_x      = data[15:0];
         REG_LIMIT_Y:      pointer_cfg.limit_y      = data[15:0];
         REG_SWAP_BUTTONS: pointer_cfg.swap_buttons = data[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
   endtask

   // Registers change only once the block is empty; a set-position transfer gives no
   // report, so an extra wait covers one still in the two-stage pipeline.
   task automatic apply_settings(input cfg_type c);
      wait_drained();
      repeat (4) @(posedge clock);
      write_register(REG_BASE_THRESH, 32'(c.base_thresh));
      write_register(REG_BOOST_THRESH, 32'(c.boost_thresh));
      write_register(REG_ACCEL_STEPS, 32'(c.accel_steps));
      write_register(REG_LIMIT_X, 32'(c.limit_x));
      write_register(REG_LIMIT_Y, 32'(c.limit_y));
      write_register(REG_SWAP_BUTTONS, 32'(c.swap_buttons));
   endtask

   function automatic logic [15:0] random_limit();
      case ($urandom_range(7))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(3000, 1));
      endcase
   endfunction

   function automatic cfg_type phase_settings(input int phase);
      cfg_type c;
      case (phase)
         0: begin
            c = '{base_thresh: 16'hFFFF, boost_thresh: 16'hFFFF, accel_steps: 2'd2,
                  limit_x: 16'hFFFF, limit_y: 16'hFFFF, swap_buttons: 1'b1};
         end
         1: begin
            c = '{base_thresh: 16'd0, boost_thresh: 16'd0, accel_steps: 2'd1,
                  limit_x: 16'hFFFF, limit_y: 16'($urandom_range(4000)), swap_buttons: 1'b0};
         end
         default: begin
            c.base_thresh  = ($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(300));
            c.boost_thresh = ($urandom_range(3) == 0) ? 16'($urandom)
                             : c.base_thresh + 16'($urandom_range(600));
            c.accel_steps  = 2'($urandom_range(3));
            c.limit_x      = random_limit();
            c.limit_y      = random_limit();
            c.swap_buttons = 1'($urandom_range(1));
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [15:0] random_delta();
      int mag;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            // Aim just below, at and just above one of the thresholds.
            mag = ($urandom_range(3) == 0) ? int'(pointer_cfg.boost_thresh)
                                           : int'(pointer_cfg.base_thresh);
            mag = mag + $urandom_range(2) - 1;
            if (mag < 0) mag = 0;
            if (mag > 32768) mag = $urandom_range(32768);
            return $urandom_range(1) ? 16'(-mag) : 16'(mag);
         end
         4: begin
            case ($urandom_range(3))
               0:       return 16'sh8000;
               1:       return 16'sh7FFF;
               2:       return 16'sd0;
               default: return -16'sd1;
            endcase
         end
         5, 6:    return 16'($urandom);
         default: return 16'($urandom_range(600)) - 16'sd300;
      endcase
   endfunction

   function automatic item_type random_event();
      item_type it;
      int       pick;
      it.value = random_delta();
      it.new_x = 16'($urandom);
      it.new_y = 16'($urandom);
      pick     = $urandom_range(99);
      if (pick < 30) begin
         it.func = FUNC_MOVE_X;
      end else if (pick < 58) begin
         it.func = FUNC_MOVE_Y;
      end else if (pick < 70) begin
         it.func = FUNC_WHEEL;
      end else if (pick < 86) begin
         it.func = 3'(FUNC_BUTTON0) + 3'($urandom_range(2));
      end else if (pick < 95) begin
         it.func = FUNC_SET_POS;
         if ($urandom_range(1)) it.new_x = 16'($urandom_range(pointer_cfg.limit_x));
         if ($urandom_range(1)) it.new_y = 16'($urandom_range(pointer_cfg.limit_y));
      end else begin
         it.func = FUNC_UNUSED;
      end
      return it;
   endfunction

   task automatic test_reset_state();
      // With every register at zero both limits pin the pointer at the origin.
      send_event(FUNC_MOVE_X, 16'sd5);
      send_event(FUNC_WHEEL, 16'sd0);
   endtask

   task automatic test_acceleration();
      apply_settings('{base_thresh: 16'd10, boost_thresh: 16'd100, accel_steps: 2'd2,
                       limit_x: 16'd1000, limit_y: 16'hFFFF, swap_buttons: 1'b0});
      send_event(FUNC_MOVE_X, 16'sd10);
      send_event(FUNC_MOVE_X, 16'sd11);
      send_event(FUNC_MOVE_Y, 16'sd101);
      send_event(FUNC_MOVE_X, 16'sh8000);
      send_event(FUNC_MOVE_X, 16'sh7FFF);
      send_event(FUNC_SET_POS, 16'sd0, 16'hFFFF, 16'hFFFF);
      send_event(FUNC_MOVE_Y, 16'sd1);
      send_event(FUNC_MOVE_X, -16'sd1);
      apply_settings('{base_thresh: 16'd0, boost_thresh: 16'd0, accel_steps: 2'd3,
                       limit_x: 16'hFFFF, limit_y: 16'hFFFF, swap_buttons: 1'b0});
      send_event(FUNC_SET_POS, 16'sd0, 16'd100, 16'd100);
      send_event(FUNC_MOVE_X, 16'sd1);
      send_event(FUNC_MOVE_Y, -16'sd1);
      send_event(FUNC_MOVE_X, 16'sd0);
   endtask

   task automatic test_wheel();
      send_event(FUNC_WHEEL, 16'sh7FFF);
      send_event(FUNC_WHEEL, 16'sh8000);
      send_event(FUNC_WHEEL, 16'sd0);
      send_event(FUNC_WHEEL, -16'sd1);
   endtask

   task automatic test_buttons();
      cfg_type swapped;
      send_event(FUNC_BUTTON0, 16'sh0080);
      send_event(FUNC_BUTTON0, 16'sh007F);
      send_event(FUNC_BUTTON1, 16'shFF80);
      send_event(FUNC_BUTTON1, 16'sh0000);
      send_event(FUNC_BUTTON2, 16'sh0080);
      send_event(FUNC_BUTTON2, 16'shFF7F);
      swapped              = pointer_cfg;
      swapped.swap_buttons = 1'b1;
      apply_settings(swapped);
      send_event(FUNC_BUTTON0, 16'sh0080);
      send_event(FUNC_BUTTON1, 16'sh0000);
      send_event(FUNC_UNUSED, 16'sh1234, 16'hA5A5, 16'h5A5A);
   endtask

   task automatic test_backpressure();
      item_type it;
      apply_settings(phase_settings(2));
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
      @(posedge clock);
      hold_left = HOLD_OFF_CYCLES;
      repeat (30) begin
         it = random_event();
         send_event(it.func, it.value, it.new_x, it.new_y);
      end
      wait_drained();
   endtask

   task automatic test_random_phases();
      int       sent;
      item_type it;
      for (int phase = 0; phase < 8; phase++) begin
         apply_settings(phase_settings(phase));
         case (phase % 4)
            0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_gap_pct = 50; rx_stall_pct = 0;  end
            2:       begin tx_gap_pct = 0;  rx_stall_pct = 50; end
            default: begin tx_gap_pct = 36; rx_stall_pct = 36; end
         endcase
         sent = 0;
         while (sent < PHASE_EVENTS) begin
            it = random_event();
            send_event(it.func, it.value, it.new_x, it.new_y);
            if (it.func != FUNC_UNUSED) sent++;
            if ($urandom_range(63) == 0) wait_drained();
         end
      end
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
   endtask

   // The receiver side: random stalls, or a long hold-off counted down here.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reports_due.size() == 0) begin
            report_mismatch("transfer with no report due", rsp_ch.event_res, 0);
         end else begin
            want = reports_due.pop_front();
            if (rsp_ch.event_res !== want.event_res) begin
               report_mismatch("event_res", rsp_ch.event_res, want.event_res);
            end
            if (rsp_ch.pos_x_out !== want.pos_x_out) begin
               report_mismatch("pos_x_out", rsp_ch.pos_x_out, want.pos_x_out);
            end
            if (rsp_ch.pos_y_out !== want.pos_y_out) begin
               report_mismatch("pos_y_out", rsp_ch.pos_y_out, want.pos_y_out);
            end
            if (rsp_ch.wheel_out !== want.wheel_out) begin
               report_mismatch("wheel_out", rsp_ch.wheel_out, want.wheel_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t no transfer for %0d cycles, %0d reports due", $time, quiet_cycles,
                  reports_due.size());
         $display("mouse_pointer_tracker verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset        = 1'b1;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      req_ch.valid = 1'b0;
      req_ch.func  = 3'd0;
      req_ch.value = 16'sd0;
      req_ch.new_x = 16'd0;
      req_ch.new_y = 16'd0;
      rsp_ch.ready = 1'b0;
      pointer_cfg  = '0;
      track_x      = 16'd0;
      track_y      = 16'd0;
      wheel_sum    = 32'sd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_acceleration();
      test_wheel();
      test_buttons();
      test_backpressure();
      test_random_phases();

      wait_drained();
      repeat (8) @(posedge clock);
      if (reports_due.size() != 0) begin
         report_mismatch("reports still due at the end", reports_due.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("mouse_pointer_tracker verification clean");
      end else begin
         $display("mouse_pointer_tracker verification failed");
      end
      $finish;
   end

endmodule

@@ mouse_pointer_tracker.f @@
design/mpt_pkg.sv
design/mpt_if.sv
design/mpt_core.sv
design/mouse_pointer_tracker.sv
tb/mouse_pointer_tracker_tb.sv
